// ===== src/krt_pkg.sv =====
// shared types and codes for the keyed record table
`default_nettype none

package krt_pkg;

    localparam int KEY_W   = 32;
    localparam int AGE_W   = 8;
    localparam int SCORE_W = 10;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [AGE_W-1:0]   age;
        logic [SCORE_W-1:0] score;
    } rec_t;

endpackage

`default_nettype wire

// ===== src/krt_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/keyed_record_table.sv =====
// keyed record table: packed record store with linear search and delete compaction
// lookup miss, insert and delete miss scan all n filled entries, n = fill count
// lookup hit or duplicate at index h stops the scan there; delete hit at h scans, then compacts the entries above h
// the single read port of the record ram sets the rate: one entry per cycle
// invalid-key lookups and unused opcodes finish from idle without a scan; one request at a time
// reset clears the fill count and control; ram contents are left as they are, no clearing pass
`default_nettype none

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [KEY_W-1:0]   record_key,
    input  wire logic [AGE_W-1:0]   record_age,
    input  wire logic [SCORE_W-1:0] record_score,
    output logic                    done,
    output logic [2:0]              status,
    output logic [6:0]              entry_index,
    output logic [AGE_W-1:0]        found_age,
    output logic [SCORE_W-1:0]      found_score,
    output logic [7:0]              fill_count
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    function automatic logic [6:0] idx7(input logic [AW-1:0] a);
        logic [AW+6:0] e;
        e = {7'd0, a};
        return e[6:0];
    endfunction

    function automatic logic [7:0] cnt8(input logic [CNT_W-1:0] c);
        logic [CNT_W+7:0] e;
        e = {8'd0, c};
        return e[7:0];
    endfunction

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic [AW-1:0]    hit_reg, hit_next;
    logic             done_reg, done_next;

    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [AGE_W-1:0]   age_reg;
    logic [SCORE_W-1:0] score_reg;
    logic               load_req;

    logic [2:0]         status_reg, status_next;
    logic [6:0]         idx_reg, idx_next;
    logic [AGE_W-1:0]   oage_reg, oage_next;
    logic [SCORE_W-1:0] oscore_reg, oscore_next;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [$bits(rec_t)-1:0] rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [$bits(rec_t)-1:0] wr_data;
    rec_t             rd_rec;
    rec_t             new_rec;
    logic [CNT_W-1:0] issue_m1;

    assign rd_rec   = rec_t'(rd_data);
    assign issue_m1 = issue_reg - CNT_W'(1);

    always_comb
    begin
        new_rec.key   = key_reg;
        new_rec.age   = age_reg;
        new_rec.score = score_reg;
    end

    krt_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        idx_next        = idx_reg;
        oage_next       = oage_reg;
        oscore_next     = oscore_reg;
        load_req        = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    load_req    = 1'b1;
                    issue_next  = '0;
                    idx_next    = 7'd0;
                    oage_next   = '0;
                    oscore_next = '0;
                    case (opcode)
                        OP_LOOKUP:
                        begin
                            if (record_key[KEY_W-1])
                            begin
                                done_next   = 1'b1;
                                status_next = ST_INVALID;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_INSERT, OP_DELETE:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (pend_valid_reg && rd_rec.key == key_reg)
                begin
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_OK;
                            idx_next    = idx7(pend_idx_reg);
                            oage_next   = rd_rec.age;
                            oscore_next = rd_rec.score;
                            state_next  = S_IDLE;
                        end
                        OP_INSERT:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_DUPLICATE;
                            state_next  = S_IDLE;
                        end
                        default:
                        begin
                            hit_next   = pend_idx_reg;
                            issue_next = CNT_W'(pend_idx_reg) + CNT_W'(1);
                            state_next = S_SHIFT;
                        end
                    endcase
                end
                else if (!pend_valid_reg && issue_reg >= count_reg)
                begin
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                    status_next = ST_NOT_FOUND;
                    if (op_reg == OP_INSERT)
                    begin
                        if (count_reg >= DEPTH_CNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[AW-1:0];
                            wr_data     = new_rec;
                            count_next  = count_reg + CNT_W'(1);
                            status_next = ST_OK;
                            idx_next    = idx7(count_reg[AW-1:0]);
                        end
                    end
                end
                else if (issue_reg < count_reg)
                begin
                    rd_en           = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_reg[AW-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                end
            end

            S_SHIFT:
            begin
                if (pend_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_idx_reg;
                    wr_data = rd_data;
                end
                if (issue_reg < count_reg)
                begin
                    rd_en           = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_idx_next   = issue_m1[AW-1:0];
                    issue_next      = issue_reg + CNT_W'(1);
                end
                else if (!pend_valid_reg)
                begin
                    count_next  = count_reg - CNT_W'(1);
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    idx_next    = idx7(hit_reg);
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            issue_reg      <= '0;
            pend_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            issue_reg      <= issue_next;
            pend_valid_reg <= pend_valid_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        hit_reg      <= hit_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        oage_reg     <= oage_next;
        oscore_reg   <= oscore_next;
        if (load_req)
        begin
            op_reg    <= opcode;
            key_reg   <= record_key;
            age_reg   <= record_age;
            score_reg <= record_score;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_index = idx_reg;
    assign found_age   = oage_reg;
    assign found_score = oscore_reg;
    assign fill_count  = cnt8(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count above table depth");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> state_reg != S_IDLE)
        else $error("ram write while idle");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither working nor done");

    a_fail_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status_reg == ST_OK || idx_reg == 7'd0))
        else $error("failed request with nonzero index");

    a_count_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> done_reg)
        else $error("fill count changed without a result");

endmodule

`default_nettype wire
